// ----- design/rc4_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned PERM_DEPTH   = 256;
  localparam int unsigned KEY_DEPTH_DEF = 256;

  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  typedef struct packed {
    logic              action;
    logic [BYTE_W-1:0] byte_value;
    logic              key_end;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              keyed;
  } out_t;

endpackage

`default_nettype wire

// ----- design/rc4_stream_cipher_top.sv -----
// A keyed data byte runs ST_PJ, ST_PT and ST_DONE into the output register; a pass-through
// byte goes from ST_DONE into it. A new byte is taken only once the last reaches ST_DONE, set by
// the three dependent accesses to the single-read-port permutation memory (S[i], S[j], then
// the keystream entry). A final key byte starts an identity fill of all 256 entries and a key
// schedule (ST_KJ then ST_KSW each step); input is stalled until both end. Reset clears indices,
// counts and handshake state; the permutation and key memories are left undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module rc4_stream_cipher_top #(
  parameter int unsigned KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire rc4_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output rc4_pkg::out_t     out_data_o
);

  localparam int unsigned KA_W  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int unsigned LEN_W = $clog2(KEY_DEPTH + 1);
  localparam int unsigned BW    = rc4_pkg::BYTE_W;
  localparam int unsigned PA_W  = $clog2(rc4_pkg::PERM_DEPTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_KJ   = 3'd2;
  localparam logic [2:0] ST_KSW  = 3'd3;
  localparam logic [2:0] ST_PJ   = 3'd4;
  localparam logic [2:0] ST_PT   = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  localparam logic [PA_W-1:0] IDX_LAST = PA_W'(rc4_pkg::PERM_DEPTH - 1);

  // memories
  logic [BW-1:0] perm_mem [rc4_pkg::PERM_DEPTH];
  logic [BW-1:0] key_mem  [KEY_DEPTH];

  logic            pm_we, pm_re;
  logic [PA_W-1:0] pm_waddr, pm_raddr;
  logic [BW-1:0]   pm_wdata, pm_rdata_q;
  logic            km_we, km_re;
  logic [BW-1:0]   km_rdata_q;

  // control
  logic [2:0]       state_q, state_d;
  logic [PA_W-1:0]  i_q, i_d, j_q, j_d;
  logic [LEN_W-1:0] fill_q, fill_d, len_q, len_d;
  logic [KA_W-1:0]  kidx_q, kidx_d;
  logic             ready_q, ready_d;
  logic             out_valid_q, out_valid_d;

  // payload
  logic [BW-1:0]    data_q, data_d, si_q, si_d, sj_q, sj_d;
  logic             keyed_q, keyed_d, fwd_q, fwd_d;
  rc4_pkg::out_t    out_q, out_d;

  logic            out_free, accept, room, load;
  logic [PA_W-1:0] i_inc, j_new, t_idx;
  logic [LEN_W-1:0] kidx_inc;
  logic [BW-1:0]   ks;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) || ((state_q == ST_DONE) && out_free));
  assign accept   = in_valid_i && !in_stall_o;
  assign room     = fill_q < LEN_W'(KEY_DEPTH);
  assign i_inc    = i_q + PA_W'(1);
  assign kidx_inc = LEN_W'(kidx_q) + LEN_W'(1);
  assign ks       = fwd_q ? sj_q : pm_rdata_q;
  assign load     = (state_q == ST_DONE) && out_free;

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    fill_d   = fill_q;
    len_d    = len_q;
    kidx_d   = kidx_q;
    ready_d  = ready_q;
    data_d   = data_q;
    keyed_d  = keyed_q;
    si_d     = si_q;
    sj_d     = sj_q;
    fwd_d    = fwd_q;
    pm_we    = 1'b0;
    pm_re    = 1'b0;
    pm_waddr = i_q;
    pm_wdata = pm_rdata_q;
    pm_raddr = i_inc;
    km_we    = 1'b0;
    km_re    = 1'b0;
    j_new    = j_q + pm_rdata_q;
    t_idx    = si_q + pm_rdata_q;
    out_d    = out_q;

    if (load) begin
      out_d.out_byte = keyed_q ? (data_q ^ ks) : data_q;
      out_d.keyed    = keyed_q;
      state_d        = ST_IDLE;
    end

    unique case (state_q)
      ST_INIT: begin
        // fill the table with the identity, then prefetch S[0] and the first key byte
        pm_we    = 1'b1;
        pm_waddr = i_q;
        pm_wdata = i_q;
        i_d      = i_inc;
        if (i_q == IDX_LAST) begin
          pm_re   = 1'b1;
          km_re   = 1'b1;
          state_d = ST_KJ;
        end
      end
      ST_KJ: begin
        j_new    = j_q + pm_rdata_q + km_rdata_q;
        j_d      = j_new;
        si_d     = pm_rdata_q;
        pm_re    = 1'b1;
        pm_raddr = j_new;
        pm_we    = 1'b1;
        pm_waddr = j_new;
        pm_wdata = pm_rdata_q;
        state_d  = ST_KSW;
      end
      ST_KSW: begin
        // finish the swap, advance the step and prefetch the next S[n] and key byte
        pm_we    = 1'b1;
        pm_waddr = i_q;
        pm_wdata = pm_rdata_q;
        pm_re    = 1'b1;
        km_re    = 1'b1;
        i_d      = i_inc;
        kidx_d   = (kidx_inc == len_q) ? '0 : kidx_inc[KA_W-1:0];
        if (i_q == IDX_LAST) begin
          j_d     = '0;
          ready_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_KJ;
        end
      end
      ST_PJ: begin
        j_d      = j_new;
        si_d     = pm_rdata_q;
        pm_re    = 1'b1;
        pm_raddr = j_new;
        pm_we    = 1'b1;
        pm_waddr = j_new;
        pm_wdata = pm_rdata_q;
        state_d  = ST_PT;
      end
      ST_PT: begin
        // S[i] is written this cycle, so forward it if the keystream index hits it
        sj_d     = pm_rdata_q;
        pm_we    = 1'b1;
        pm_waddr = i_q;
        pm_wdata = pm_rdata_q;
        pm_re    = 1'b1;
        pm_raddr = t_idx;
        fwd_d    = (t_idx == i_q);
        state_d  = ST_DONE;
      end
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          if (in_data_i.action == rc4_pkg::ACT_DATA) begin
            data_d = in_data_i.byte_value;
            if (ready_q) begin
              keyed_d = 1'b1;
              i_d     = i_inc;
              pm_re   = 1'b1;
              state_d = ST_PJ;
            end else begin
              keyed_d = 1'b0;
              state_d = ST_DONE;
            end
          end else begin
            if (room) begin
              km_we  = 1'b1;
              fill_d = fill_q + LEN_W'(1);
            end
            if (in_data_i.key_end) begin
              len_d   = room ? (fill_q + LEN_W'(1)) : fill_q;
              fill_d  = '0;
              i_d     = '0;
              j_d     = '0;
              kidx_d  = '0;
              ready_d = 1'b0;
              state_d = ST_INIT;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      fill_q      <= '0;
      len_q       <= '0;
      kidx_q      <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      kidx_q      <= kidx_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    keyed_q <= keyed_d;
    si_q    <= si_d;
    sj_q    <= sj_d;
    fwd_q   <= fwd_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      perm_mem[pm_waddr] <= pm_wdata;
    end
    if (pm_re) begin
      pm_rdata_q <= perm_mem[pm_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (km_we) begin
      key_mem[fill_q[KA_W-1:0]] <= in_data_i.byte_value;
    end
    if (km_re) begin
      km_rdata_q <= key_mem[kidx_d];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- design/rc4_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rc4_chk (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire rc4_pkg::in_t  in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire rc4_pkg::out_t out_data_o
);

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result beat changed while stalled");

  // handshake outputs stay known once out of reset
  a_hs_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(out_valid_o) && !$isunknown(in_stall_o))
    else $error("handshake output unknown");

  // the schedule starts after the final key byte, so input must stall
  a_sched_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (in_data_i.action == rc4_pkg::ACT_KEY) && in_data_i.key_end |=> in_stall_o)
    else $error("input taken during key schedule");

endmodule

bind rc4_stream_cipher_top rc4_chk u_rc4_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ----- verif/rc4_cipher_checker.sv -----
`timescale 1ns / 1ps

module rc4_cipher_checker #(
  parameter int unsigned KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_stall_i,
  input  wire rc4_pkg::in_t  in_data_i,
  input  wire logic          out_valid_i,
  input  wire logic          out_stall_i,
  input  wire rc4_pkg::out_t out_data_i,
  output int unsigned        mismatches_o,
  output int unsigned        pending_o,
  output int unsigned        compared_o,
  output int unsigned        schedules_o
);

  import rc4_pkg::*;

  localparam int unsigned PRINT_CAP = 50;

  logic [BYTE_W-1:0] sbox [PERM_DEPTH];
  logic [BYTE_W-1:0] key_mem [PERM_DEPTH];
  logic [8:0]        fill_cnt;
  logic [8:0]        key_len;
  logic [BYTE_W-1:0] idx_i;
  logic [BYTE_W-1:0] idx_j;
  logic              have_key;

  out_t        cipher_bytes_q [$];
  out_t        want;
  int unsigned errors;
  int unsigned compared;
  int unsigned schedules;

  initial errors = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    errors++;
    if (errors <= PRINT_CAP)
      $display("%0t ns rc4 check: %s got %02h wanted %02h", $time, what, got, exp_val);
  endtask

  // Identity fill, then the 256-step schedule over the stored key.
  task automatic schedule_key();
    logic [BYTE_W-1:0] jv;
    logic [BYTE_W-1:0] kb;
    logic [BYTE_W-1:0] t;
    jv = '0;
    for (int n = 0; n < PERM_DEPTH; n++) sbox[n] = n[BYTE_W-1:0];
    for (int n = 0; n < PERM_DEPTH; n++) begin
      kb = (key_len != 0) ? key_mem[n % key_len] : '0;
      jv = jv + sbox[n] + kb;
      t = sbox[n];
      sbox[n] = sbox[jv];
      sbox[jv] = t;
    end
    idx_i = '0;
    idx_j = '0;
    have_key = 1'b1;
  endtask

  task automatic cipher_byte(input in_t beat);
    logic [BYTE_W-1:0] t;
    logic [BYTE_W-1:0] sum;
    out_t res;
    if (beat.action == ACT_KEY) begin
      // drop key bytes past the store depth
      if (fill_cnt < KEY_DEPTH) begin
        key_mem[fill_cnt[7:0]] = beat.byte_value;
        fill_cnt = fill_cnt + 9'd1;
      end
      if (beat.key_end) begin
        key_len = fill_cnt;
        fill_cnt = '0;
        schedule_key();
        schedules++;
      end
    end else begin
      if (!have_key) begin
        res.out_byte = beat.byte_value;
        res.keyed = 1'b0;
      end else begin
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + sbox[idx_i];
        t = sbox[idx_i];
        sbox[idx_i] = sbox[idx_j];
        sbox[idx_j] = t;
        sum = sbox[idx_i] + sbox[idx_j];
        res.out_byte = beat.byte_value ^ sbox[sum];
        res.keyed = 1'b1;
      end
      cipher_bytes_q.push_back(res);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt = '0;
      key_len = '0;
      idx_i = '0;
      idx_j = '0;
      have_key = 1'b0;
      compared = 0;
      schedules = 0;
      cipher_bytes_q.delete();
      mismatches_o <= errors;
      pending_o <= 0;
      compared_o <= 0;
      schedules_o <= 0;
    end else begin
      // check the result beat first: no result leaves in the cycle of its own input
      if (out_valid_i && !out_stall_i) begin
        if (cipher_bytes_q.size() == 0) begin
          report_mismatch("result beat with nothing expected", out_data_i.out_byte, 0);
        end else begin
          want = cipher_bytes_q.pop_front();
          if (out_data_i.out_byte !== want.out_byte)
            report_mismatch("out_byte", out_data_i.out_byte, want.out_byte);
          if (out_data_i.keyed !== want.keyed)
            report_mismatch("keyed", out_data_i.keyed, want.keyed);
          compared++;
        end
      end
      if (in_valid_i && !in_stall_i) cipher_byte(in_data_i);
      mismatches_o <= errors;
      pending_o <= cipher_bytes_q.size();
      compared_o <= compared;
      schedules_o <= schedules;
    end
  end

endmodule

// ----- verif/rc4_stream_cipher_top_test.sv -----
`timescale 1ns / 1ps

module rc4_stream_cipher_top_test;

  import rc4_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_TAIL  = 1000;
  localparam int unsigned PHASE_ITEMS = 270;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_beat   = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_beat;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent     = 0;
  int unsigned idle_cycles    = 0;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned compared;
  int unsigned schedules;

  rc4_stream_cipher_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_beat)
  );

  rc4_cipher_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_beat),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_beat),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .compared_o   (compared),
    .schedules_o  (schedules)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("no beat moved for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beat(input logic act, input logic [BYTE_W-1:0] val, input logic ke);
    in_t b;
    b.action = act;
    b.byte_value = val;
    b.key_end = ke;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_key(input int unsigned len);
    for (int unsigned k = 0; k < len; k++)
      send_beat(ACT_KEY, 8'($urandom_range(0, 255)), k == len - 1);
  endtask

  // Data burst with the odd stray key byte and the odd key_end mark on data.
  task automatic send_data(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(0, 19) == 0) send_beat(ACT_KEY, 8'($urandom_range(0, 255)), 1'b0);
      send_beat(ACT_DATA, 8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
    end
  endtask

  // Hold the sender until the checker has nothing left outstanding.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned start;
    int unsigned p;
    int unsigned q;
    int unsigned klen;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      p = $urandom_range(0, 99);
      if (p < 70) begin
        q = $urandom_range(0, 99);
        if (q < 2) klen = $urandom_range(0, 1) ? 256 : $urandom_range(257, 300);
        else if (q < 12) klen = $urandom_range(17, 64);
        else klen = $urandom_range(1, 16);
        send_key(klen);
        send_data($urandom_range(1, 40));
      end else if (p < 85) begin
        repeat ($urandom_range(1, 8))
          send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
      end else begin
        // unfinished key: these bytes lead the next key
        repeat ($urandom_range(1, 6)) send_beat(ACT_KEY, 8'($urandom_range(0, 255)), 1'b0);
        send_data($urandom_range(1, 10));
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pass-through before any key, key_end on data ignored
    send_beat(ACT_DATA, 8'h00, 1'b0);
    send_beat(ACT_DATA, 8'hFF, 1'b1);
    send_beat(ACT_DATA, 8'hA5, 1'b0);
    // one-byte key of zero
    send_beat(ACT_KEY, 8'h00, 1'b1);
    send_beat(ACT_DATA, 8'h00, 1'b0);
    send_beat(ACT_DATA, 8'hFF, 1'b0);
    send_beat(ACT_DATA, 8'h5A, 1'b1);
    // three-byte key, then a short message
    send_beat(ACT_KEY, 8'h4B, 1'b0);
    send_beat(ACT_KEY, 8'h65, 1'b0);
    send_beat(ACT_KEY, 8'h79, 1'b1);
    send_beat(ACT_DATA, 8'h50, 1'b0);
    send_beat(ACT_DATA, 8'h6C, 1'b0);
    send_beat(ACT_DATA, 8'h61, 1'b0);
    send_beat(ACT_DATA, 8'h69, 1'b0);
    send_beat(ACT_DATA, 8'h6E, 1'b0);
    send_beat(ACT_DATA, 8'h74, 1'b0);
    send_beat(ACT_DATA, 8'h65, 1'b0);
    send_beat(ACT_DATA, 8'h78, 1'b0);
    send_beat(ACT_DATA, 8'h74, 1'b0);
    // key byte while keyed must leave the keystream alone
    send_beat(ACT_KEY, 8'h11, 1'b0);
    send_beat(ACT_DATA, 8'h00, 1'b0);
    send_beat(ACT_DATA, 8'hFF, 1'b0);
    send_beat(ACT_KEY, 8'hFF, 1'b1);
    send_beat(ACT_DATA, 8'h12, 1'b0);
    send_beat(ACT_DATA, 8'h34, 1'b0);
    wait_drained();

    // full-depth key, then an overflowing key whose end mark falls past the store
    send_key(256);
    send_data(20);
    send_key(300);
    send_data(20);

    run_phase(0, 0);
    run_phase(78, 0);
    run_phase(0, 78);
    run_phase(30, 30);

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk_i);

    $display("Sent %0d beats with %0d key schedules; %0d cipher bytes checked,",
             items_sent, schedules, compared);
    $display("with free flow, sender gaps, receiver back-pressure and both together.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
